// ----- src/sprite_slot_texture_unit_allocator_macros.svh -----
// ----------------------------------------------------------------------------
// sprite slot texture unit allocator assertion macros
// shared concurrent assertion forms used at the top level
// ----------------------------------------------------------------------------
`ifndef SPRITE_SLOT_TEXTURE_UNIT_ALLOCATOR_MACROS_SVH
`define SPRITE_SLOT_TEXTURE_UNIT_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define SSTA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define SSTA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/ssta_pkg.sv -----
// ----------------------------------------------------------------------------
// ssta_pkg
// types and codes shared by the slot and texture unit allocator
// ----------------------------------------------------------------------------
package ssta_pkg;

    localparam logic       MODE_TAKE    = 1'b0;
    localparam logic       MODE_RELEASE = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    localparam logic [1:0] CFG_SLOTS   = 2'd0;
    localparam logic [1:0] CFG_BATCHES = 2'd1;
    localparam logic [1:0] CFG_UNITS   = 2'd2;

    typedef struct packed {
        logic        mode;
        logic [1:0]  layer;
        logic [11:0] tex_index;
        logic [3:0]  batch;
        logic [5:0]  slot;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] out_layer;
        logic [3:0] out_batch;
        logic [5:0] out_slot;
        logic [3:0] tex_unit;
        logic       new_batch;
    } t_rsp;

    typedef struct packed {
        logic load_req;
        logic clr_scan;
        logic rd_row;
        logic step_b;
        logic commit_take;
        logic activate;
        logic commit_rel;
        logic set_full;
        logic set_bad;
    } t_cmd;

    typedef struct packed {
        logic is_release;
        logic layer_ok;
        logic fit;
        logic scan_end;
        logic inactive_found;
        logic rel_ok;
    } t_stat;

endpackage

// ----- src/ssta_req_if.sv -----
// ----------------------------------------------------------------------------
// ssta_req_if
// request channel: valid, ready and one request
// ----------------------------------------------------------------------------
interface ssta_req_if;
    import ssta_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/ssta_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ssta_rsp_if
// result channel: valid, ready and one result
// ----------------------------------------------------------------------------
interface ssta_rsp_if;
    import ssta_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/sprite_slot_texture_unit_allocator.sv -----
// ----------------------------------------------------------------------------
// sprite_slot_texture_unit_allocator
// per-layer batch slot allocator with reference-counted texture units
// ----------------------------------------------------------------------------
// channel   dir  handshake            payload
// i_req     in   valid/ready          mode, layer, tex_index, batch, slot
// o_rsp     out  valid/ready          status, out_layer, out_batch, out_slot,
//                                     tex_unit, new_batch
// i_cfg_*   in   write enable only    index, data
//
// one request at a time; take decodes the request, then for each scanned batch
// reads and evaluates its row of the slot and unit store, then hands off the result
// release decodes, then does one row read and one write back before the hand-off
// no clearing pass: activation rewrites its row, reset clears the batch flags
// a stalled result holds the block; the next request waits until it is taken
module sprite_slot_texture_unit_allocator #(
    parameter int LAYERS  = 4,
    parameter int BATCHES = 16,
    parameter int SLOTS   = 64,
    parameter int UNITS   = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ssta_req_if.sink   i_req,
    ssta_rsp_if.source o_rsp,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [6:0] i_cfg_data
);
    import ssta_pkg::*;

    `include "sprite_slot_texture_unit_allocator_macros.svh"

    t_cmd  cmd;
    t_stat stat;

    ssta_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    ssta_dp #(
        .LAYERS  (LAYERS),
        .BATCHES (BATCHES),
        .SLOTS   (SLOTS),
        .UNITS   (UNITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (i_req.data),
        .o_rsp      (o_rsp.data),
        .i_cmd      (cmd),
        .o_stat     (stat)
    );

    `SSTA_ASSERT_NXT(a_busy_after_req, i_clk, i_rst_n, i_req.valid && i_req.ready, !i_req.ready)
    `SSTA_ASSERT_IMP(a_no_req_while_rsp, i_clk, i_rst_n, o_rsp.valid, !i_req.ready)
    `SSTA_ASSERT_IMP(a_activate_has_room, i_clk, i_rst_n, cmd.activate, stat.inactive_found && !stat.fit)

endmodule

// ----- src/ssta_ctrl.sv -----
// ----------------------------------------------------------------------------
// ssta_ctrl
// sequencer: request decode, batch scan, commit and result hand-off
// ----------------------------------------------------------------------------
module ssta_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    output logic            o_rsp_valid,
    input  logic            i_rsp_ready,
    input  ssta_pkg::t_stat i_stat,
    output ssta_pkg::t_cmd  o_cmd
);
    import ssta_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_T_RD = 3'd2;
    localparam logic [2:0] S_T_EV = 3'd3;
    localparam logic [2:0] S_R_RD = 3'd4;
    localparam logic [2:0] S_R_EV = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] r_state, n_state;

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_DEC;
                end
            end
            S_DEC: begin
                if (i_stat.is_release) begin
                    n_state = S_R_RD;
                end else if (!i_stat.layer_ok) begin
                    o_cmd.set_full = 1'b1;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.clr_scan = 1'b1;
                    n_state        = S_T_RD;
                end
            end
            S_T_RD: begin
                o_cmd.rd_row = 1'b1;
                n_state      = S_T_EV;
            end
            S_T_EV: begin
                if (i_stat.fit) begin
                    o_cmd.commit_take = 1'b1;
                    n_state           = S_OUT;
                end else if (i_stat.scan_end) begin
                    // no active batch fits: open a fresh one or report full
                    if (i_stat.inactive_found) o_cmd.activate = 1'b1;
                    else o_cmd.set_full = 1'b1;
                    n_state = S_OUT;
                end else begin
                    o_cmd.step_b = 1'b1;
                    n_state      = S_T_RD;
                end
            end
            S_R_RD: begin
                o_cmd.rd_row = 1'b1;
                n_state      = S_R_EV;
            end
            S_R_EV: begin
                if (i_stat.rel_ok) o_cmd.commit_rel = 1'b1;
                else o_cmd.set_bad = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_rsp_ready) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

endmodule

// ----- src/ssta_dp.sv -----
// ----------------------------------------------------------------------------
// ssta_dp
// datapath: configuration, request register, batch rows and slot unit store
// ----------------------------------------------------------------------------
module ssta_dp #(
    parameter int LAYERS  = 4,
    parameter int BATCHES = 16,
    parameter int SLOTS   = 64,
    parameter int UNITS   = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [6:0]      i_cfg_data,
    input  ssta_pkg::t_req  i_req,
    output ssta_pkg::t_rsp  o_rsp,
    input  ssta_pkg::t_cmd  i_cmd,
    output ssta_pkg::t_stat o_stat
);
    import ssta_pkg::*;

    localparam int ROWS = LAYERS * BATCHES;
    localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int BW   = (BATCHES > 1) ? $clog2(BATCHES) : 1;
    localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int UW   = (UNITS > 1) ? $clog2(UNITS) : 1;
    localparam int SAW  = (ROWS * SLOTS > 1) ? $clog2(ROWS * SLOTS) : 1;
    localparam int SCW  = $clog2(SLOTS + 1);
    localparam int BCW  = $clog2(BATCHES + 1);
    localparam int UCW  = $clog2(UNITS + 1);

    logic [6:0] r_cfg_slots;
    logic [4:0] r_cfg_batches;
    logic [4:0] r_cfg_units;
    t_req       r_req;
    logic [BW-1:0] r_b;
    logic [ROWS-1:0] r_active;
    t_rsp       r_rsp;

    logic [SLOTS-1:0]            r_slot_mem [ROWS];
    logic [UNITS-1:0][6:0]       r_refs_mem [ROWS];
    logic [UNITS-1:0][11:0]      r_tex_mem  [ROWS];
    logic [UW-1:0]               r_sunit_mem [ROWS*SLOTS];

    logic [SLOTS-1:0]       r_srow_q;
    logic [UNITS-1:0][6:0]  r_refs_q;
    logic [UNITS-1:0][11:0] r_tex_q;
    logic [UW-1:0]          r_sunit_q;

    logic [SCW-1:0] ns;
    logic [BCW-1:0] nb;
    logic [UCW-1:0] nu;
    logic [AW-1:0]  scan_bi, key_bi, new_bi, rd_bi, w_bi;
    logic [SAW-1:0] key_sa, w_sa;
    logic [SW-1:0]  fs, ks;
    logic           fs_found;
    logic [UW-1:0]  match_u, free_u, sel_u;
    logic           match_found, free_found;
    logic [BW-1:0]  nbi;
    logic           nbi_found;
    logic           key_ok;
    logic           w_en;
    logic [SLOTS-1:0]       w_srow;
    logic [UNITS-1:0][6:0]  w_refs;
    logic [UNITS-1:0][11:0] w_tex;
    logic           su_we;
    logic [UW-1:0]  su_wd;

    // register values of zero count as one, oversize as the parameter
    always_comb begin
        if (r_cfg_slots == '0) ns = SCW'(1);
        else if (int'(r_cfg_slots) > SLOTS) ns = SCW'(SLOTS);
        else ns = SCW'(r_cfg_slots);
        if (r_cfg_batches == '0) nb = BCW'(1);
        else if (int'(r_cfg_batches) > BATCHES) nb = BCW'(BATCHES);
        else nb = BCW'(r_cfg_batches);
        if (r_cfg_units == '0) nu = UCW'(1);
        else if (int'(r_cfg_units) > UNITS) nu = UCW'(UNITS);
        else nu = UCW'(r_cfg_units);
    end

    assign ks      = SW'(r_req.slot);
    assign scan_bi = AW'(int'(r_req.layer) * BATCHES + int'(r_b));
    assign key_bi  = AW'(int'(r_req.layer) * BATCHES + int'(r_req.batch));
    assign key_sa  = SAW'(int'(key_bi) * SLOTS + int'(ks));
    assign rd_bi   = (r_req.mode == MODE_RELEASE) ? key_bi : scan_bi;
    assign key_ok  = (int'(r_req.layer) < LAYERS) && (int'(r_req.batch) < BATCHES)
                  && (int'(r_req.slot) < SLOTS);

    // lowest free slot in the fetched row
    always_comb begin
        fs       = '0;
        fs_found = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if (!fs_found && (i < int'(ns)) && !r_srow_q[i]) begin
                fs       = SW'(i);
                fs_found = 1'b1;
            end
        end
    end

    // unit already holding the texture, else first unused one
    always_comb begin
        match_u     = '0;
        free_u      = '0;
        match_found = 1'b0;
        free_found  = 1'b0;
        for (int i = 0; i < UNITS; i++) begin
            if (i < int'(nu)) begin
                if (r_refs_q[i] == 7'd0) begin
                    if (!free_found) begin
                        free_u     = UW'(i);
                        free_found = 1'b1;
                    end
                end else if (r_tex_q[i] == r_req.tex_index && !match_found) begin
                    match_u     = UW'(i);
                    match_found = 1'b1;
                end
            end
        end
        sel_u = match_found ? match_u : free_u;
    end

    // lowest inactive batch of the layer
    always_comb begin
        nbi       = '0;
        nbi_found = 1'b0;
        for (int b = 0; b < BATCHES; b++) begin
            if (!nbi_found && (b < int'(nb))
                && !r_active[AW'(int'(r_req.layer) * BATCHES + b)]) begin
                nbi       = BW'(b);
                nbi_found = 1'b1;
            end
        end
        new_bi = AW'(int'(r_req.layer) * BATCHES + int'(nbi));
    end

    always_comb begin
        o_stat.is_release     = (r_req.mode == MODE_RELEASE);
        o_stat.layer_ok       = (int'(r_req.layer) < LAYERS);
        o_stat.fit            = r_active[scan_bi] && fs_found && (match_found || free_found);
        o_stat.scan_end       = (int'(r_b) + 1 >= int'(nb));
        o_stat.inactive_found = nbi_found;
        o_stat.rel_ok         = key_ok && r_active[key_bi] && r_srow_q[ks];
    end

    // row write data for commit, activation and release
    always_comb begin
        w_en   = 1'b0;
        w_bi   = scan_bi;
        w_srow = r_srow_q;
        w_refs = r_refs_q;
        w_tex  = r_tex_q;
        su_we  = 1'b0;
        su_wd  = sel_u;
        w_sa   = SAW'(int'(scan_bi) * SLOTS + int'(fs));
        if (i_cmd.commit_take) begin
            w_en          = 1'b1;
            w_srow[fs]    = 1'b1;
            if (w_refs[sel_u] != 7'd127) w_refs[sel_u] = w_refs[sel_u] + 7'd1;
            w_tex[sel_u]  = r_req.tex_index;
            su_we         = 1'b1;
        end else if (i_cmd.activate) begin
            // a cleared batch grants slot zero on unit zero
            w_en       = 1'b1;
            w_bi       = new_bi;
            w_srow     = '0;
            w_srow[0]  = 1'b1;
            w_refs     = '0;
            w_refs[0]  = 7'd1;
            w_tex      = '0;
            w_tex[0]   = r_req.tex_index;
            su_we      = 1'b1;
            su_wd      = '0;
            w_sa       = SAW'(int'(new_bi) * SLOTS);
        end else if (i_cmd.commit_rel) begin
            w_en       = 1'b1;
            w_bi       = key_bi;
            w_srow[ks] = 1'b0;
            if (w_refs[r_sunit_q] != 7'd0) w_refs[r_sunit_q] = w_refs[r_sunit_q] - 7'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_slot_mem[w_bi] <= w_srow;
            r_refs_mem[w_bi] <= w_refs;
            r_tex_mem[w_bi]  <= w_tex;
        end
        if (i_cmd.rd_row) begin
            r_srow_q <= r_slot_mem[rd_bi];
            r_refs_q <= r_refs_mem[rd_bi];
            r_tex_q  <= r_tex_mem[rd_bi];
        end
    end

    always_ff @(posedge i_clk) begin
        if (su_we) r_sunit_mem[w_sa] <= su_wd;
        if (i_cmd.rd_row) r_sunit_q <= r_sunit_mem[key_sa];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_slots   <= 7'd64;
            r_cfg_batches <= 5'd16;
            r_cfg_units   <= 5'd16;
            r_active      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SLOTS:   r_cfg_slots   <= i_cfg_data;
                    CFG_BATCHES: r_cfg_batches <= i_cfg_data[4:0];
                    CFG_UNITS:   r_cfg_units   <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (i_cmd.activate) r_active[new_bi] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) r_req <= i_req;
        if (i_cmd.clr_scan) r_b <= '0;
        else if (i_cmd.step_b) r_b <= r_b + BW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit_take) begin
            r_rsp <= '{ST_OK, r_req.layer, 4'(r_b), 6'(fs), 4'(sel_u), 1'b0};
        end else if (i_cmd.activate) begin
            r_rsp <= '{ST_OK, r_req.layer, 4'(nbi), 6'd0, 4'd0, 1'b1};
        end else if (i_cmd.set_full) begin
            r_rsp <= '{ST_FULL, r_req.layer, 4'd0, 6'd0, 4'd0, 1'b0};
        end else if (i_cmd.commit_rel) begin
            r_rsp <= '{ST_OK, r_req.layer, r_req.batch, r_req.slot, 4'(r_sunit_q), 1'b0};
        end else if (i_cmd.set_bad) begin
            r_rsp <= '{ST_BAD, r_req.layer, r_req.batch, r_req.slot, 4'd0, 1'b0};
        end
    end

    assign o_rsp = r_rsp;

endmodule
